// ===== src/loc_pkg.sv =====
// ----------------------------------------------------------------------------
// loc_pkg
// Shared types and constants of the literal occurrence counter.
// ----------------------------------------------------------------------------
package loc_pkg;

    localparam int LIT_W    = 12;
    localparam int OP_W     = 2;
    localparam int CFG_W    = 11;
    localparam int CNT_W    = 17;
    localparam int VAR_W    = 18;
    localparam int SUM_W    = 32;
    localparam int CLAUSE_W = 17;

    localparam int MAX_ATOMS_DEF   = 1024;
    localparam int MAX_CLAUSES_DEF = 65536;
    localparam int CLAUSE_CAP      = 131071;

    localparam logic [CNT_W-1:0] COUNT_MAX     = 17'h10000;
    localparam logic [CFG_W-1:0] NUM_ATOMS_RST = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_COUNT = 2'd0,
        OP_SUM   = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [CLAUSE_W-1:0] pos_stamp;
        logic [CLAUSE_W-1:0] neg_stamp;
        logic [CNT_W-1:0]    pos_cnt;
        logic [CNT_W-1:0]    neg_cnt;
    } entry_t;

    typedef struct packed {
        opcode_t op;
        logic    neg;
        logic    last;
        logic    valid;
    } item_t;

    typedef struct packed {
        logic             status;
        logic [CNT_W-1:0] positive_count;
        logic [CNT_W-1:0] negative_count;
        logic [VAR_W-1:0] variable_count;
        logic [SUM_W-1:0] clause_literal_sum;
        logic [SUM_W-1:0] clause_variable_sum;
    } result_t;

endpackage

// ===== src/loc_atom_mem.sv =====
// ----------------------------------------------------------------------------
// loc_atom_mem
// Per-atom store of counts and clause stamps, one read and one write port,
// registered read data, zeroed by a sweep after reset.
// ----------------------------------------------------------------------------
module loc_atom_mem #(
    parameter int MAX_ATOMS = loc_pkg::MAX_ATOMS_DEF,
    parameter int AW        = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output loc_pkg::entry_t  rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  loc_pkg::entry_t  wr_data,
    output logic             clear_busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ATOMS - 1);

    loc_pkg::entry_t mem [MAX_ATOMS];

    logic          busy_reg;
    logic [AW-1:0] sweep_reg;

    assign clear_busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else if (busy_reg)
        begin
            sweep_reg <= sweep_reg + 1'b1;
            if (sweep_reg == LAST_ADDR)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[sweep_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/loc_exec.sv =====
// ----------------------------------------------------------------------------
// loc_exec
// Update logic for one transaction: new atom entry, clause number,
// accumulators and the result.
// ----------------------------------------------------------------------------
module loc_exec #(
    parameter int MAX_CLAUSES = loc_pkg::MAX_CLAUSES_DEF
) (
    input  loc_pkg::item_t                     item,
    input  loc_pkg::entry_t                    rd_entry,
    input  logic [loc_pkg::CLAUSE_W-1:0]       clause_no,
    input  logic [loc_pkg::SUM_W-1:0]          lit_acc,
    input  logic [loc_pkg::SUM_W-1:0]          var_acc,
    output loc_pkg::entry_t                    wr_entry,
    output logic                               wr_en,
    output logic                               has_result,
    output loc_pkg::result_t                   result,
    output logic [loc_pkg::CLAUSE_W-1:0]       clause_next,
    output logic [loc_pkg::SUM_W-1:0]          lit_acc_next,
    output logic [loc_pkg::SUM_W-1:0]          var_acc_next
);

    localparam int CLAUSE_LIMIT =
        (MAX_CLAUSES > loc_pkg::CLAUSE_CAP) ? loc_pkg::CLAUSE_CAP : MAX_CLAUSES;
    localparam logic [loc_pkg::CLAUSE_W-1:0] CLAUSE_MAX = loc_pkg::CLAUSE_W'(CLAUSE_LIMIT);

    logic [loc_pkg::CLAUSE_W-1:0] clause_adv;
    logic [loc_pkg::CNT_W-1:0]    lit_freq;
    logic [loc_pkg::VAR_W-1:0]    var_freq;
    logic [loc_pkg::SUM_W:0]      lit_sum;
    logic [loc_pkg::SUM_W:0]      var_sum;
    logic [loc_pkg::SUM_W-1:0]    lit_sat;
    logic [loc_pkg::SUM_W-1:0]    var_sat;

    always_comb
    begin
        clause_adv = (clause_no < CLAUSE_MAX) ? clause_no + 1'b1 : clause_no;
        lit_freq   = item.neg ? rd_entry.neg_cnt : rd_entry.pos_cnt;
        var_freq   = loc_pkg::VAR_W'(rd_entry.pos_cnt) + loc_pkg::VAR_W'(rd_entry.neg_cnt);
        lit_sum    = {1'b0, lit_acc} + (loc_pkg::SUM_W + 1)'(lit_freq);
        var_sum    = {1'b0, var_acc} + (loc_pkg::SUM_W + 1)'(var_freq);
        lit_sat    = lit_sum[loc_pkg::SUM_W] ? '1 : lit_sum[loc_pkg::SUM_W-1:0];
        var_sat    = var_sum[loc_pkg::SUM_W] ? '1 : var_sum[loc_pkg::SUM_W-1:0];
    end

    always_comb
    begin
        wr_entry     = rd_entry;
        wr_en        = 1'b0;
        has_result   = 1'b1;
        result       = '0;
        clause_next  = clause_no;
        lit_acc_next = lit_acc;
        var_acc_next = var_acc;

        unique case (item.op)
            loc_pkg::OP_COUNT:
            begin
                if (item.valid)
                begin
                    has_result = 1'b0;
                    wr_en      = 1'b1;
                    // A literal already stamped with this clause was counted before.
                    if (item.neg && rd_entry.neg_stamp != clause_no)
                    begin
                        wr_entry.neg_stamp = clause_no;
                        if (rd_entry.neg_cnt < loc_pkg::COUNT_MAX)
                        begin
                            wr_entry.neg_cnt = rd_entry.neg_cnt + 1'b1;
                        end
                    end
                    else if (!item.neg && rd_entry.pos_stamp != clause_no)
                    begin
                        wr_entry.pos_stamp = clause_no;
                        if (rd_entry.pos_cnt < loc_pkg::COUNT_MAX)
                        begin
                            wr_entry.pos_cnt = rd_entry.pos_cnt + 1'b1;
                        end
                    end
                end
                else
                begin
                    result.status = 1'b1;
                end
                if (item.last)
                begin
                    clause_next = clause_adv;
                end
            end
            loc_pkg::OP_SUM:
            begin
                if (item.valid)
                begin
                    lit_acc_next = lit_sat;
                    var_acc_next = var_sat;
                end
                if (item.last)
                begin
                    if (item.valid)
                    begin
                        result.clause_literal_sum  = lit_sat;
                        result.clause_variable_sum = var_sat;
                    end
                    else
                    begin
                        result.status = 1'b1;
                    end
                    lit_acc_next = '0;
                    var_acc_next = '0;
                end
                else if (item.valid)
                begin
                    has_result = 1'b0;
                end
                else
                begin
                    result.status = 1'b1;
                end
            end
            loc_pkg::OP_QUERY:
            begin
                if (item.valid && !item.neg)
                begin
                    result.positive_count = rd_entry.pos_cnt;
                    result.negative_count = rd_entry.neg_cnt;
                    result.variable_count = var_freq;
                end
                else
                begin
                    result.status = 1'b1;
                end
            end
            default:
            begin
                result.status = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/literal_occurrence_counter.sv =====
// Result: registered in the output register after the atom memory read of its input
// transaction, provided the output register is free.
// Input: one transaction at a time is taken, as the read of the atom memory is followed
// by its write-back before the next one; a stalled result holds the update stage.
// Reset: asynchronous, active low; afterwards a clearing pass writes all MAX_ATOMS entries
// of the atom memory and s_tready rises in the cycle after it ends.
// ----------------------------------------------------------------------------
// literal_occurrence_counter
// Counts clause occurrences of each literal, answers atom queries and forms
// per-clause frequency sums.
// ----------------------------------------------------------------------------
module literal_occurrence_counter #(
    parameter int MAX_ATOMS   = loc_pkg::MAX_ATOMS_DEF,
    parameter int MAX_CLAUSES = loc_pkg::MAX_CLAUSES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [loc_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,   // [11:0] literal, [15:12] zero
    input  logic [1:0]                s_tuser,   // [1:0] opcode
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [16:0] positive_count, [33:17] negative_count, [51:34] variable_count,
    // [83:52] clause_literal_sum, [115:84] clause_variable_sum, [119:116] zero
    output logic [119:0]              m_tdata,
    output logic                      m_tuser    // [0] status
);

    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

    loc_pkg::state_t state_reg;
    loc_pkg::state_t state_next;

    logic [loc_pkg::CFG_W-1:0]    num_atoms_reg;
    logic [loc_pkg::CLAUSE_W-1:0] clause_reg;
    logic [loc_pkg::SUM_W-1:0]    lit_acc_reg;
    logic [loc_pkg::SUM_W-1:0]    var_acc_reg;
    loc_pkg::item_t               item_reg;
    logic [AW-1:0]                addr_reg;
    logic                         out_valid_reg;
    loc_pkg::result_t             out_reg;

    logic [loc_pkg::LIT_W-1:0]    raw;
    logic                         neg;
    logic [loc_pkg::LIT_W-1:0]    mag;
    logic [16:0]                  mag_m1;
    logic                         lit_ok;
    logic [AW-1:0]                rd_addr;
    logic                         accept;
    logic                         out_free;
    logic                         exec_done;
    logic                         clear_busy;

    loc_pkg::entry_t              rd_entry;
    loc_pkg::entry_t              wr_entry;
    logic                         wr_en;
    logic                         has_result;
    loc_pkg::result_t             result;
    logic [loc_pkg::CLAUSE_W-1:0] clause_next;
    logic [loc_pkg::SUM_W-1:0]    lit_acc_next;
    logic [loc_pkg::SUM_W-1:0]    var_acc_next;

    // Literal decode: two's complement magnitude; the most negative code maps to 2048.
    always_comb
    begin
        raw     = s_tdata[loc_pkg::LIT_W-1:0];
        neg     = raw[loc_pkg::LIT_W-1];
        mag     = neg ? (~raw + 1'b1) : raw;
        mag_m1  = 17'(mag) - 17'd1;
        rd_addr = mag_m1[AW-1:0];
        lit_ok  = (mag != '0) && (mag <= loc_pkg::LIT_W'(num_atoms_reg))
                  && (32'(mag) <= MAX_ATOMS);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            loc_pkg::ST_CLEAR:
            begin
                if (!clear_busy)
                begin
                    state_next = loc_pkg::ST_IDLE;
                end
            end
            loc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = loc_pkg::ST_EXEC;
                end
            end
            loc_pkg::ST_EXEC:
            begin
                if (!has_result || out_free)
                begin
                    state_next = loc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = loc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == loc_pkg::ST_IDLE);
        accept    = s_tready && s_tvalid;
        out_free  = !out_valid_reg || m_tready;
        exec_done = (state_reg == loc_pkg::ST_EXEC) && (!has_result || out_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= loc_pkg::ST_CLEAR;
            num_atoms_reg <= loc_pkg::NUM_ATOMS_RST;
            clause_reg    <= loc_pkg::CLAUSE_W'(1);
            lit_acc_reg   <= '0;
            var_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                num_atoms_reg <= cfg_wr_data;
            end
            if (exec_done)
            begin
                clause_reg  <= clause_next;
                lit_acc_reg <= lit_acc_next;
                var_acc_reg <= var_acc_next;
            end
            if (exec_done && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op    <= loc_pkg::opcode_t'(s_tuser);
            item_reg.neg   <= neg;
            item_reg.last  <= s_tlast;
            item_reg.valid <= lit_ok;
            addr_reg       <= rd_addr;
        end
        if (exec_done && has_result)
        begin
            out_reg <= result;
        end
    end

    loc_atom_mem #(
        .MAX_ATOMS (MAX_ATOMS),
        .AW        (AW)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (rd_addr),
        .rd_data    (rd_entry),
        .wr_en      (exec_done && wr_en),
        .wr_addr    (addr_reg),
        .wr_data    (wr_entry),
        .clear_busy (clear_busy)
    );

    loc_exec #(
        .MAX_CLAUSES (MAX_CLAUSES)
    ) u_exec (
        .item         (item_reg),
        .rd_entry     (rd_entry),
        .clause_no    (clause_reg),
        .lit_acc      (lit_acc_reg),
        .var_acc      (var_acc_reg),
        .wr_entry     (wr_entry),
        .wr_en        (wr_en),
        .has_result   (has_result),
        .result       (result),
        .clause_next  (clause_next),
        .lit_acc_next (lit_acc_next),
        .var_acc_next (var_acc_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {4'b0000,
                       out_reg.clause_variable_sum,
                       out_reg.clause_literal_sum,
                       out_reg.variable_count,
                       out_reg.negative_count,
                       out_reg.positive_count};

endmodule

// ===== src/loc_checker.sv =====
// ----------------------------------------------------------------------------
// loc_checker
// Port-level checks of the literal occurrence counter, bound to the top level.
// ----------------------------------------------------------------------------
module loc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic         m_tuser
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Each item needs a memory read before the next one can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    // An error result carries no counts and no sums.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result with nonzero payload");

    // The variable count is always the sum of the two literal counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[51:34] == (18'(m_tdata[16:0]) + 18'(m_tdata[33:17])))
        else $error("variable count mismatch");

endmodule

bind literal_occurrence_counter loc_checker u_loc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
